[rtl/msgrt_pkg.sv]
// package: types, sizes and command struct for the message reassembly tracker
package msgrt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // one received packet
  typedef struct packed {
    logic [15:0] message_id;
    logic [7:0]  message_packets;
    logic [7:0]  packet_index;
    logic [31:0] injection_time;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        message_done;
    logic [15:0] done_id;
    logic [31:0] done_time;
    logic        table_overflow;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } dp_cmd_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } ctrl_state_t;

endpackage

[rtl/msgrt_ctrl.sv]
// controller: sequences load, table search and update, owns the output valid
module msgrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output msgrt_pkg::dp_cmd_t cmd
);

  msgrt_pkg::ctrl_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // handshake and commands
  assign in_ready   = (state_r == msgrt_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.search = (state_r == msgrt_pkg::S_LOOK);
  assign cmd.commit = (state_r == msgrt_pkg::S_UPD) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msgrt_pkg::S_IDLE: begin
        if (cmd.load) state_nxt = msgrt_pkg::S_LOOK;
      end
      msgrt_pkg::S_LOOK: begin
        state_nxt = msgrt_pkg::S_UPD;
      end
      msgrt_pkg::S_UPD: begin
        if (cmd.commit) state_nxt = msgrt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = msgrt_pkg::S_IDLE;
      end
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msgrt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item goes straight to the search
  a_load_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == msgrt_pkg::S_LOOK))
    else $error("accepted item did not enter search");

  // search is always followed by update
  a_look_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msgrt_pkg::S_LOOK) |=> (state_r == msgrt_pkg::S_UPD))
    else $error("search not followed by update");

  // a commit never overwrites a result that is not taken
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit into occupied output slot");

endmodule

[rtl/msgrt_dp.sv]
// datapath: open message table, id match, entry update and result register
module msgrt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msgrt_pkg::dp_cmd_t   cmd,
  input  msgrt_pkg::in_item_t  in_data,
  output msgrt_pkg::out_item_t out_data
);

  localparam int DEPTH = msgrt_pkg::TABLE_DEPTH;
  localparam int IW    = msgrt_pkg::IDX_W;

  // table storage
  logic [DEPTH-1:0] valid_r;
  logic [15:0]      id_r    [DEPTH];
  logic [7:0]       size_r  [DEPTH];
  logic [7:0]       count_r [DEPTH];
  logic [31:0]      time_r  [DEPTH];

  // item and search results
  msgrt_pkg::in_item_t  item_r;
  msgrt_pkg::out_item_t res_r, res_nxt;
  logic                 hit_r, hit_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic                 free_r, free_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;

  logic        single;
  logic [7:0]  cnt_inc;
  logic [31:0] upd_time;
  logic        hit_done;

  // parallel id match, lowest index wins
  always_comb begin
    hit_nxt      = 1'b0;
    hit_idx_nxt  = '0;
    free_nxt     = 1'b0;
    free_idx_nxt = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && (id_r[i] == item_r.message_id)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = IW'(i);
      end
      if (!valid_r[i]) begin
        free_nxt     = 1'b1;
        free_idx_nxt = IW'(i);
      end
    end
  end

  // entry update values
  assign single   = (item_r.message_packets == 8'd1);
  assign cnt_inc  = count_r[hit_idx_r] + 8'd1;
  assign upd_time = (item_r.packet_index == 8'd1) ? item_r.injection_time
                                                  : time_r[hit_idx_r];
  assign hit_done = (cnt_inc == size_r[hit_idx_r]);

  // result of this item
  always_comb begin
    res_nxt = '0;
    if (single) begin
      res_nxt.message_done = 1'b1;
      res_nxt.done_id      = item_r.message_id;
      res_nxt.done_time    = item_r.injection_time;
    end else if (!hit_r) begin
      res_nxt.table_overflow = !free_r;
    end else if (hit_done) begin
      res_nxt.message_done = 1'b1;
      res_nxt.done_id      = id_r[hit_idx_r];
      res_nxt.done_time    = upd_time;
    end
  end

  // item and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.search) begin
      hit_r      <= hit_nxt;
      hit_idx_r  <= hit_idx_nxt;
      free_r     <= free_nxt;
      free_idx_r <= free_idx_nxt;
    end
    if (cmd.commit) res_r <= res_nxt;
  end

  // entry payload writes
  always_ff @(posedge clk) begin
    if (cmd.commit && !single) begin
      if (!hit_r) begin
        if (free_r) begin
          id_r[free_idx_r]    <= item_r.message_id;
          size_r[free_idx_r]  <= item_r.message_packets;
          count_r[free_idx_r] <= 8'd1;
          time_r[free_idx_r]  <= item_r.injection_time;
        end
      end else begin
        count_r[hit_idx_r] <= cnt_inc;
        time_r[hit_idx_r]  <= upd_time;
      end
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !single) begin
      if (!hit_r) begin
        if (free_r) valid_r[free_idx_r] <= 1'b1;
      end else if (hit_done) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  assign out_data = res_r;

  // overflow is only reported on a full table
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_nxt.table_overflow) |-> (&valid_r))
    else $error("overflow reported with a free entry");

  // a completion frees exactly one entry
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !single && hit_r && hit_done) |=>
      ($countones(valid_r) + 1 == $countones($past(valid_r))))
    else $error("completion did not free one entry");

  // a one-packet message leaves the table untouched
  a_single_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && single) |=> (valid_r == $past(valid_r)))
    else $error("one-packet message changed the table");

endmodule

[rtl/message_reassembly_tracker_unit.sv]
// top level: message reassembly tracker, controller plus table datapath
// result: the item is searched, then the update registers it, stalling while the output is full
// a new item is taken only after the previous one has left the search and update states
// a new item is taken while the previous result still waits in the output register
// reset (rst_n low, synchronous) clears the controller, output valid and all entry
// valid bits at once; no clearing pass, entry payload is not reset
module message_reassembly_tracker_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msgrt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msgrt_pkg::out_item_t out_data
);

  msgrt_pkg::dp_cmd_t cmd;

  // sequencing and handshakes
  msgrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // table and result datapath
  msgrt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

[verif/message_reassembly_tracker_unit_tb.sv]
// testbench for the message reassembly tracker: directed table, random packet streams, self-check
module message_reassembly_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 8;
  localparam int DIR_ROWS     = 25;

  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;
  localparam msgrt_pkg::out_item_t NO_RESULT = '0;

  // one directed row: packet, whether the result is typed in, typed result
  typedef struct packed {
    msgrt_pkg::in_item_t  pkt;
    logic                 typed;
    msgrt_pkg::out_item_t want;
  } dir_row_t;

  // packet fields: id, packets, index, time | typed | done, id, time, overflow
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // one-packet messages at the field extremes
    {16'hFFFF, 8'd1,   8'd1,   32'hFFFF_FFFF, TYPED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0},
    {16'h0000, 8'd1,   8'd0,   32'h0000_0000, TYPED, 1'b1, 16'h0000, 32'h0000_0000, 1'b0},
    // fill all sixteen entries, none with its first packet
    {16'h0100, 8'd2,   8'd2,   32'h0000_1000, TYPED, NO_RESULT},
    {16'h0101, 8'd2,   8'd2,   32'h0000_1001, TYPED, NO_RESULT},
    {16'h0102, 8'd2,   8'd2,   32'h0000_1002, TYPED, NO_RESULT},
    {16'h0103, 8'd2,   8'd2,   32'h0000_1003, TYPED, NO_RESULT},
    {16'h0104, 8'd2,   8'd2,   32'h0000_1004, TYPED, NO_RESULT},
    {16'h0105, 8'd2,   8'd2,   32'h0000_1005, TYPED, NO_RESULT},
    {16'h0106, 8'd2,   8'd2,   32'h0000_1006, TYPED, NO_RESULT},
    {16'h0107, 8'd2,   8'd2,   32'h0000_1007, TYPED, NO_RESULT},
    {16'h0108, 8'd2,   8'd2,   32'h0000_1008, TYPED, NO_RESULT},
    {16'h0109, 8'd2,   8'd2,   32'h0000_1009, TYPED, NO_RESULT},
    {16'h010A, 8'd2,   8'd2,   32'h0000_100A, TYPED, NO_RESULT},
    {16'h010B, 8'd2,   8'd2,   32'h0000_100B, TYPED, NO_RESULT},
    {16'h010C, 8'd2,   8'd2,   32'h0000_100C, TYPED, NO_RESULT},
    {16'h010D, 8'd2,   8'd0,   32'h0000_100D, TYPED, NO_RESULT},
    // size zero entry, completes only when its count wraps
    {16'h010E, 8'd0,   8'd2,   32'h0000_100E, TYPED, NO_RESULT},
    {16'h010F, 8'd255, 8'd255, 32'hFFFF_FFFF, TYPED, NO_RESULT},
    // table full: new message dropped
    {16'h0200, 8'd3,   8'd1,   32'h0000_0123, TYPED, 1'b0, 16'h0000, 32'h0000_0000, 1'b1},
    // first packet late: its time replaces the stored one
    {16'h0100, 8'd2,   8'd1,   32'hAAAA_5555, TYPED, 1'b1, 16'h0100, 32'hAAAA_5555, 1'b0},
    // one-packet message whose id is open bypasses the table
    {16'h0101, 8'd1,   8'd1,   32'h0000_0077, TYPED, 1'b1, 16'h0101, 32'h0000_0077, 1'b0},
    // later packets' size ignored, odd indexes
    {16'h0101, 8'd9,   8'd0,   32'h0000_0088, PRED,  NO_RESULT},
    {16'h0102, 8'd255, 8'd200, 32'h0000_0005, PRED,  NO_RESULT},
    // lowest free entry reused, then completed
    {16'h0200, 8'd2,   8'd1,   32'h0000_0006, PRED,  NO_RESULT},
    {16'h0200, 8'd0,   8'd2,   32'h0000_0007, PRED,  NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  msgrt_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  msgrt_pkg::out_item_t out_data;

  // own copy of the open-message table
  logic        tbl_valid [msgrt_pkg::TABLE_DEPTH];
  logic [15:0] tbl_id    [msgrt_pkg::TABLE_DEPTH];
  logic [7:0]  tbl_size  [msgrt_pkg::TABLE_DEPTH];
  logic [7:0]  tbl_count [msgrt_pkg::TABLE_DEPTH];
  logic [31:0] tbl_time  [msgrt_pkg::TABLE_DEPTH];

  msgrt_pkg::out_item_t pending_reports [$];
  msgrt_pkg::out_item_t want;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 19;
  int        recv_idle_pct = 77;
  int        hold_req = 0;

  message_reassembly_tracker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("message_reassembly_tracker_unit regression: fail");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // next state and report of the table for one packet
  function automatic msgrt_pkg::out_item_t track_packet(input msgrt_pkg::in_item_t pkt);
    msgrt_pkg::out_item_t res;
    int hit;
    int free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    if (pkt.message_packets == 8'd1) begin
      res.message_done = 1'b1;
      res.done_id      = pkt.message_id;
      res.done_time    = pkt.injection_time;
      return res;
    end
    // lowest matching valid entry, lowest free entry
    for (int i = 0; i < msgrt_pkg::TABLE_DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_id[i] == pkt.message_id) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        res.table_overflow = 1'b1;
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_id[free_slot]    = pkt.message_id;
        tbl_size[free_slot]  = pkt.message_packets;
        tbl_count[free_slot] = 8'd1;
        tbl_time[free_slot]  = pkt.injection_time;
      end
      return res;
    end
    if (pkt.packet_index == 8'd1) tbl_time[hit] = pkt.injection_time;
    tbl_count[hit] = tbl_count[hit] + 8'd1;
    if (tbl_count[hit] == tbl_size[hit]) begin
      tbl_valid[hit]   = 1'b0;
      res.message_done = 1'b1;
      res.done_id      = tbl_id[hit];
      res.done_time    = tbl_time[hit];
    end
    return res;
  endfunction

  // offer one packet from a falling edge, predict once it is taken
  task automatic send_packet(input msgrt_pkg::in_item_t pkt, input bit typed,
                             input msgrt_pkg::out_item_t typed_res);
    msgrt_pkg::out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = track_packet(pkt);
    pending_reports.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = pending_reports.pop_front();
        if (out_data.message_done !== want.message_done)
          report($sformatf("message_done got %0b want %0b",
                           out_data.message_done, want.message_done));
        if (out_data.done_id !== want.done_id)
          report($sformatf("done_id got %h want %h", out_data.done_id, want.done_id));
        if (out_data.done_time !== want.done_time)
          report($sformatf("done_time got %h want %h", out_data.done_time, want.done_time));
        if (out_data.table_overflow !== want.table_overflow)
          report($sformatf("table_overflow got %0b want %0b",
                           out_data.table_overflow, want.table_overflow));
      end
    end
  end

  // stimulus
  initial begin
    msgrt_pkg::in_item_t pkt;
    int       open_slots [$];
    int       leader;
    int       kind;
    int       roll;
    int       k;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int i = 0; i < msgrt_pkg::TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i]    = '0;
      tbl_size[i]  = '0;
      tbl_count[i] = '0;
      tbl_time[i]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++)
      send_packet(DIRECTED_ROWS[r].pkt, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

    // random packet streams
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 19;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
      end
      // open entries and the one furthest along
      open_slots.delete();
      leader = -1;
      for (int i = 0; i < msgrt_pkg::TABLE_DEPTH; i++) begin
        if (tbl_valid[i]) begin
          open_slots.push_back(i);
          if (leader < 0 || tbl_count[i] > tbl_count[leader]) leader = i;
        end
      end
      // noise by default, shaped below
      pkt.message_id      = 16'($urandom_range(65535));
      pkt.message_packets = 8'($urandom_range(255));
      pkt.packet_index    = 8'($urandom_range(255));
      pkt.injection_time  = $urandom;
      kind = $urandom_range(99);
      if (kind < 65 && open_slots.size() > 0) begin
        // next packet of an open message, often the one furthest along
        k = ($urandom_range(99) < 60) ? leader
                                      : open_slots[$urandom_range(open_slots.size() - 1)];
        pkt.message_id = tbl_id[k];
        roll = $urandom_range(9);
        if (roll < 8) pkt.packet_index = tbl_count[k] + 8'd1;
        else if (roll == 8) pkt.packet_index = 8'd1;
        if (pkt.message_packets == 8'd1) pkt.message_packets = tbl_size[k];
      end else if (kind < 88) begin
        // first packet of a new message, mostly short
        roll = $urandom_range(99);
        if (roll < 85) pkt.message_packets = 8'($urandom_range(6, 2));
        else if (roll < 97) pkt.message_packets = 8'($urandom_range(40, 7));
        else if (roll < 98) pkt.message_packets = 8'd0;
        else if (roll < 99) pkt.message_packets = 8'd255;
        if (pkt.message_packets == 8'd1) pkt.message_packets = 8'd2;
        if ($urandom_range(9) != 0) pkt.packet_index = 8'd1;
      end else if (kind < 94) begin
        // one-packet message, sometimes reusing an open id
        pkt.message_packets = 8'd1;
        if (open_slots.size() > 0 && $urandom_range(1) == 1)
          pkt.message_id = tbl_id[open_slots[$urandom_range(open_slots.size() - 1)]];
      end
      send_packet(pkt, PRED, NO_RESULT);
    end
    in_valid <= 1'b0;

    // drain and settle
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("message_reassembly_tracker_unit regression: pass");
    end else begin
      $display("message_reassembly_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
